FILE: design/bmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_pkg: shared types and defaults for the binary trie max-XOR block
// Holds the item payload structs, the step result flags and the default
// trie geometry.
// ----------------------------------------------------------------------------
package bmx_pkg;

  // Default trie geometry
  localparam int KEY_BITS_DEF   = 31;
  localparam int NODE_COUNT_DEF = 4096;

  // Fixed width of the key and answer fields on the ports
  localparam int FIELD_W = 31;

  // Operation codes carried in the mode field
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Input item
  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] key;
  } in_t;

  // Result item
  typedef struct packed {
    logic [FIELD_W-1:0] best_xor;
    logic [FIELD_W-1:0] max_seen;
    logic               pool_full;
  } out_t;

  // Outcome of one trie level step
  typedef struct packed {
    logic found;    // a child was taken
    logic flipped;  // the taken child is opposite to the key bit
  } step_flags_t;

endpackage

FILE: design/bmx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data. No reset on the
// array or the read data.
// ----------------------------------------------------------------------------
module bmx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/bmx_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_step: one trie level step
// Picks the child to follow from a node entry. A query prefers the child
// opposite to the key bit; an insert follows the same-bit child only.
// ----------------------------------------------------------------------------
module bmx_step #(
  parameter int IDX_W = 12
) (
  input  logic [2*IDX_W-1:0]       entry_i,
  input  logic                     key_bit_i,
  input  logic                     query_i,
  output logic [IDX_W-1:0]         next_o,
  output bmx_pkg::step_flags_t     flags_o
);
  import bmx_pkg::*;

  logic [IDX_W-1:0] child0;
  logic [IDX_W-1:0] child1;
  logic [IDX_W-1:0] same_c;
  logic [IDX_W-1:0] opp_c;

  // Split entry: upper half is the one-child, lower half the zero-child
  assign child0 = entry_i[IDX_W-1:0];
  assign child1 = entry_i[2*IDX_W-1:IDX_W];
  assign same_c = key_bit_i ? child1 : child0;
  assign opp_c  = key_bit_i ? child0 : child1;

  // Child selection; index zero means no child
  always_comb begin
    if (query_i && (opp_c != '0)) begin
      next_o          = opp_c;
      flags_o.found   = 1'b1;
      flags_o.flipped = 1'b1;
    end else begin
      next_o          = same_c;
      flags_o.found   = (same_c != '0);
      flags_o.flipped = 1'b0;
    end
  end

endmodule

FILE: design/binary_trie_max_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor: maximum-XOR query over a binary trie of stored keys
// Insert keys into a node pool and query the greatest XOR against them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o / in_data_i carries one item: mode
//   (insert or query) and a key. Output channel out_valid_o / out_ready_i /
//   out_data_o returns exactly one result item per input item.
//   The block takes one item at a time; in_ready_o is low while it works.
//   The trie levels are walked in turn: the step unit feeds the next address
//   to the single read port of the node memory, whose registered data gives
//   the entry for the next level. A query or a duplicate insert walks down
//   its path; an insert whose path ends early hangs a chain of fresh nodes
//   there; a rejected insert stops where its path ends.
//   A new item is taken only when the last one is finished; the next item
//   may be accepted while the previous result still sits in the output register.
//   Reset empties the trie (root has no children), sets the next free node to
//   one and clears the running maximum; no memory sweep is needed, as nodes
//   are written in full when allocated.
//   If the receiver stalls, the finished item waits in its sequencer until
//   the output register frees up; nothing is dropped.
// ----------------------------------------------------------------------------
module binary_trie_max_xor #(
  parameter int KEY_BITS   = bmx_pkg::KEY_BITS_DEF,
  parameter int NODE_COUNT = bmx_pkg::NODE_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bmx_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bmx_pkg::out_t out_data_o
);
  import bmx_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int NF_W  = $clog2(NODE_COUNT + 1);
  localparam int ENT_W = 2 * IDX_W;
  localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int CHK_W = ((NF_W > LVL_W) ? NF_W : LVL_W) + 1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                mode_q, mode_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [IDX_W-1:0]    node_q, node_d;
  logic [KEY_BITS-1:0] acc_q, acc_d;
  logic                full_q, full_d;
  logic [ENT_W-1:0]    root_q, root_d;
  logic [NF_W-1:0]     next_free_q, next_free_d;
  logic [KEY_BITS-1:0] max_q, max_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic [ENT_W-1:0]    rd_data;
  logic [ENT_W-1:0]    entry;
  logic                key_bit;
  logic                is_query;
  logic [IDX_W-1:0]    step_next;
  step_flags_t         step_flags;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [ENT_W-1:0]    parent_ent;
  logic [ENT_W-1:0]    alloc_ent;
  logic [IDX_W-1:0]    fresh_idx;
  logic [IDX_W-1:0]    chain_idx;
  logic                chain_bit;
  logic [CHK_W-1:0]    need_top;
  logic                reject;
  logic [KEY_BITS-1:0] max_new;

  // Node memory
  bmx_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT)
  ) u_bmx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (step_next),
    .rdata_o (rd_data)
  );

  // Current node entry: root lives in registers, others come from memory
  assign entry    = (node_q == '0) ? root_q : rd_data;
  assign key_bit  = key_q[lvl_q];
  assign is_query = (mode_q == MODE_QUERY);

  // Shared level step unit
  bmx_step #(
    .IDX_W (IDX_W)
  ) u_bmx_step (
    .entry_i   (entry),
    .key_bit_i (key_bit),
    .query_i   (is_query),
    .next_o    (step_next),
    .flags_o   (step_flags)
  );

  // Link a fresh node into the parent where the walk stopped
  assign fresh_idx  = next_free_q[IDX_W-1:0];
  assign parent_ent = key_bit ? {fresh_idx, entry[IDX_W-1:0]}
                              : {entry[ENT_W-1:IDX_W], fresh_idx};

  // Entry of a freshly allocated node: one child, the next fresh node (none at level zero)
  assign chain_idx = IDX_W'(next_free_q + NF_W'(1));
  assign chain_bit = key_q[lvl_q - LVL_W'(1)];
  assign alloc_ent = (lvl_q == '0) ? '0
                   : (chain_bit ? {chain_idx, IDX_W'(0)} : {IDX_W'(0), chain_idx});

  // Pool check: nodes missing on the path are lvl + 1
  assign need_top = CHK_W'(next_free_q) + CHK_W'(lvl_q) + CHK_W'(1);
  assign reject   = (need_top > CHK_W'(NODE_COUNT));

  assign max_new = (is_query && (acc_q > max_q)) ? acc_q : max_q;

  // Sequencer and datapath
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    mode_d      = mode_q;
    lvl_d       = lvl_q;
    node_d      = node_q;
    acc_d       = acc_q;
    full_d      = full_q;
    root_d      = root_q;
    next_free_d = next_free_q;
    max_d       = max_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = parent_ent;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = KEY_BITS'(in_data_i.key);
          mode_d  = in_data_i.mode;
          lvl_d   = LVL_W'(KEY_BITS - 1);
          node_d  = '0;
          acc_d   = '0;
          full_d  = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step_flags.found) begin
          node_d = step_next;
          if (step_flags.flipped) begin
            acc_d[lvl_q] = 1'b1;
          end
          if (lvl_q == '0) begin
            state_d = ST_DONE;
          end else begin
            lvl_d = lvl_q - LVL_W'(1);
          end
        end else if (is_query) begin
          state_d = ST_DONE;
        end else if (reject) begin
          full_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          // Hang the new chain under the stopping node
          if (node_q == '0) begin
            root_d = parent_ent;
          end else begin
            ram_we = 1'b1;
          end
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        ram_we      = 1'b1;
        ram_waddr   = fresh_idx;
        ram_wdata   = alloc_ent;
        next_free_d = next_free_q + NF_W'(1);
        if (lvl_q == '0) begin
          state_d = ST_DONE;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          max_d           = max_new;
          out_d.best_xor  = is_query ? FIELD_W'(acc_q) : '0;
          out_d.max_seen  = FIELD_W'(max_new);
          out_d.pool_full = full_q;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      root_q      <= '0;
      next_free_q <= NF_W'(1);
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_q      <= root_d;
      next_free_q <= next_free_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    mode_q <= mode_d;
    lvl_q  <= lvl_d;
    node_q <= node_d;
    acc_q  <= acc_d;
    full_q <= full_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/bmx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmx_checker: port-level checks for the binary trie max-XOR block
// Watches the two channels and the running maximum over time; bound to the
// top level below.
// ----------------------------------------------------------------------------
module bmx_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input bmx_pkg::out_t out_data_o
);
  import bmx_pkg::*;

  logic [FIELD_W-1:0] last_max_q;

  // Running maximum of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_max_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_max_q <= out_data_o.max_seen;
    end
  end

  // A result waits until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped before it was taken");

  // One item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while the walk is busy");

  // The running maximum never falls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.max_seen >= last_max_q)
    else $error("running maximum decreased");

  // The running maximum covers the current answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.max_seen >= out_data_o.best_xor)
    else $error("answer exceeds running maximum");

  // A rejected insert carries no answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pool_full |-> out_data_o.best_xor == '0)
    else $error("rejected insert with non-zero answer");

endmodule

bind binary_trie_max_xor bmx_checker u_bmx_checker (.*);
